/* design/lookup_frontier_update_core_defines.svh */
// Assertion macros for the lookup frontier update core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LOOKUP_FRONTIER_UPDATE_CORE_DEFINES_SVH
`define LOOKUP_FRONTIER_UPDATE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LFU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LFU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/lfu_pkg.sv */
// Shared types, codes and helpers of the lookup frontier update core.
// No dependencies; imported by lookup_frontier_update_core.
package lfu_pkg;

   // fixed field widths of the item channels
   localparam int TOP_W      = 32;
   localparam int MID_W      = 64;
   localparam int BOT_W      = 64;
   localparam int FULL_ID_W  = TOP_W + MID_W + BOT_W;
   localparam int IP_W       = 32;
   localparam int PORT_W     = 16;
   localparam int OP_W       = 2;
   localparam int SLOT_OUT_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int CHUNK_W    = 32;
   localparam int CHUNK_LZ_W = 5;

   // item operation codes
   typedef enum logic [OP_W-1:0] {
      OP_START     = 2'd0,
      OP_RESPONDER = 2'd1,
      OP_CANDIDATE = 2'd2,
      OP_FINISH    = 2'd3
   } op_type;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TOP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MIDDLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BOTTOM = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OWN,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // control tag that travels with each pass through the prefix unit
   typedef struct packed {
      logic valid;
      logic own;     // pass scores the item's own ID
      logic empty;   // slot was empty at issue
      logic same;    // slot ID equals the item's ID
   } pipe_tag_type;

   // leading zeros of a 32-bit word (result meaningless for a zero word)
   function automatic logic [CHUNK_LZ_W-1:0] lead_zeros32(input logic [CHUNK_W-1:0] v);
      logic [2:0] oct_lz [4];
      logic [3:0] oct_nz;
      logic [CHUNK_LZ_W-1:0] lz;
      int b;
      int k;
      for (b = 0; b < 4; b++) begin
         oct_nz[b] = |v[CHUNK_W-1-8*b -: 8];
         oct_lz[b] = 3'd7;
         // highest set bit wins
         for (k = 0; k < 8; k++) begin
            if (v[8*(3-b)+k]) oct_lz[b] = 3'(7 - k);
         end
      end
      lz = '1;
      for (b = 3; b >= 0; b--) begin
         if (oct_nz[b]) lz = {2'(b), oct_lz[b]};
      end
      return lz;
   endfunction

endpackage

/* design/lookup_frontier_update_core.sv */
// Lookup frontier update core: closest-node frontier with a shared prefix unit.
// Depends on lfu_pkg and lookup_frontier_update_core_defines.svh.
//
// Usage
//  - req_*: one item per operation (start, responder offer, candidate, finish).
//    An item is taken when req_valid is high and req_stall is low.
//  - rsp_*: exactly one result item per request item, held until taken
//    (rsp_valid high, rsp_stall low). A stalled result holds its fields.
//  - csr_*: write target ID words while no item is in flight.
// Timing
//  - Start, finish and items seen while the lookup is inactive: result valid
//    the cycle after the request is taken.
//  - Responder and candidate items while active: one pass through the
//    two-stage prefix unit for the item's own score, then one per slot, then
//    the pipeline drains and the result becomes valid.
//  - A new request is taken at the earliest in the cycle its predecessor's
//    result is taken, so the core works on one item at a time.
// Reset
//  - Synchronous reset empties the frontier, zeroes all slot IDs and the
//    target, and leaves the lookup inactive. No clearing pass is needed.
`include "lookup_frontier_update_core_defines.svh"

module lookup_frontier_update_core #(
   parameter int FRONTIER_SLOTS = 8,
   parameter int ID_WIDTH       = 160
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lfu_pkg::OP_W-1:0]        req_op,
   input  logic [lfu_pkg::TOP_W-1:0]       req_node_top,
   input  logic [lfu_pkg::MID_W-1:0]       req_node_middle,
   input  logic [lfu_pkg::BOT_W-1:0]       req_node_bottom,
   input  logic [lfu_pkg::IP_W-1:0]        req_node_ip,
   input  logic [lfu_pkg::PORT_W-1:0]      req_node_port,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_accepted,
   output logic [lfu_pkg::SLOT_OUT_W-1:0]  rsp_slot,
   output logic                            rsp_fan_out,
   output logic [lfu_pkg::IP_W-1:0]        rsp_dest_ip,
   output logic [lfu_pkg::PORT_W-1:0]      rsp_dest_port,
   // configuration port
   input  logic                            csr_wr_en,
   input  logic [lfu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lfu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lfu_pkg::*;

   localparam int SLOT_W     = $clog2(FRONTIER_SLOTS);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int NUM_CHUNKS = (ID_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_W      = NUM_CHUNKS * CHUNK_W;
   localparam int PAD_SHIFT  = PAD_W - ID_WIDTH;
   localparam int SCORE_W    = $clog2(ID_WIDTH + 1);

   // sequencer
   state_type state_ff, state_in;
   logic      req_take, rsp_take, search_in, drain_done;

   // configuration
   logic [TOP_W-1:0] target_top_ff;
   logic [MID_W-1:0] target_middle_ff;
   logic [BOT_W-1:0] target_bottom_ff;
   logic [ID_WIDTH-1:0] target_id;

   // frontier: only the ID and an occupied flag are ever read back
   logic [ID_WIDTH-1:0]       slot_id_ff [FRONTIER_SLOTS];
   logic [FRONTIER_SLOTS-1:0] slot_full_ff;
   logic                      active_ff;

   // latched item
   op_type              op_ff;
   logic [ID_WIDTH-1:0] node_id_ff;
   logic [IP_W-1:0]     node_ip_ff;
   logic [PORT_W-1:0]   node_port_ff;
   logic [ID_WIDTH-1:0] req_id;

   // issue side of the prefix unit
   logic [CNT_W-1:0]    cnt_ff;
   logic [SLOT_W-1:0]   issue_idx;
   logic [ID_WIDTH-1:0] issue_id;
   pipe_tag_type        issue_tag;

   // prefix unit stages
   logic [PAD_W-1:0]          s1_diff;
   logic [NUM_CHUNKS-1:0]     s1_nz_in, s1_nz_ff;
   logic [CHUNK_LZ_W-1:0]     s1_lz_in [NUM_CHUNKS];
   logic [CHUNK_LZ_W-1:0]     s1_lz_ff [NUM_CHUNKS];
   pipe_tag_type              s1_tag_ff, s2_tag_ff;
   logic [SLOT_W-1:0]         s1_idx_ff, s2_idx_ff;
   logic [SCORE_W-1:0]        s2_score_in, s2_score_ff;

   // scan accumulators
   logic [SCORE_W-1:0] own_score_ff, best_ff;
   logic [SLOT_W-1:0]  pick_ff;
   logic               found_ff, stop_ff, better_ff, same_ff;

   assign target_id = ID_WIDTH'({target_top_ff, target_middle_ff, target_bottom_ff});
   assign req_id    = ID_WIDTH'({req_node_top, req_node_middle, req_node_bottom});
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   // search only responders and candidates while the lookup runs
   assign search_in = active_ff &&
                      (op_type'(req_op) == OP_RESPONDER || op_type'(req_op) == OP_CANDIDATE);
   assign drain_done = !s1_tag_ff.valid && !s2_tag_ff.valid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = search_in ? ST_OWN : ST_DONE;
         end
         ST_OWN:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(FRONTIER_SLOTS - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (drain_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (req_take)      state_in = search_in ? ST_OWN : ST_DONE;
            else if (rsp_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = !(state_ff == ST_IDLE || (state_ff == ST_DONE && !rsp_stall));
      rsp_valid = (state_ff == ST_DONE);
      issue_idx = cnt_ff[SLOT_W-1:0];
      issue_tag.valid = (state_ff == ST_OWN) || (state_ff == ST_SCAN);
      issue_tag.own   = (state_ff == ST_OWN);
      issue_tag.empty = !slot_full_ff[issue_idx];
      issue_tag.same  = (node_id_ff == slot_id_ff[issue_idx]);
      issue_id = issue_tag.own ? node_id_ff : slot_id_ff[issue_idx];
   end

   // prefix stage 1: difference word, per-chunk leading zeros
   always_comb begin
      s1_diff = PAD_W'(issue_id ^ target_id) << PAD_SHIFT;
      for (int c = 0; c < NUM_CHUNKS; c++) begin
         s1_nz_in[c] = |s1_diff[PAD_W-1-c*CHUNK_W -: CHUNK_W];
         s1_lz_in[c] = lead_zeros32(s1_diff[PAD_W-1-c*CHUNK_W -: CHUNK_W]);
      end
   end

   // prefix stage 2: first differing chunk gives the common prefix length
   always_comb begin
      s2_score_in = SCORE_W'(ID_WIDTH);
      for (int c = NUM_CHUNKS - 1; c >= 0; c--) begin
         if (s1_nz_ff[c]) s2_score_in = SCORE_W'(c * CHUNK_W) + SCORE_W'(s1_lz_ff[c]);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         active_ff        <= 1'b0;
         slot_full_ff     <= '0;
         target_top_ff    <= '0;
         target_middle_ff <= '0;
         target_bottom_ff <= '0;
         s1_tag_ff        <= '0;
         s2_tag_ff        <= '0;
         for (int i = 0; i < FRONTIER_SLOTS; i++) slot_id_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         s1_tag_ff <= issue_tag;
         s2_tag_ff <= s1_tag_ff;

         // target words
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TARGET_TOP:    target_top_ff    <= csr_wdata[TOP_W-1:0];
               CSR_TARGET_MIDDLE: target_middle_ff <= csr_wdata;
               CSR_TARGET_BOTTOM: target_bottom_ff <= csr_wdata;
               default: ;
            endcase
         end

         // start empties the frontier, finish halts the lookup
         if (req_take) begin
            if (op_type'(req_op) == OP_START) begin
               slot_full_ff <= '0;
               active_ff    <= 1'b1;
            end else if (op_type'(req_op) == OP_FINISH) begin
               active_ff <= 1'b0;
            end
         end

         // store a winning responder; port zero leaves the slot empty
         if (state_ff == ST_DRAIN && drain_done && op_ff == OP_RESPONDER && found_ff) begin
            slot_id_ff[pick_ff]   <= node_id_ff;
            slot_full_ff[pick_ff] <= (node_port_ff != '0);
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s1_nz_ff    <= s1_nz_in;
      s1_lz_ff    <= s1_lz_in;
      s1_idx_ff   <= issue_idx;
      s2_idx_ff   <= s1_idx_ff;
      s2_score_ff <= s2_score_in;

      // advance the slot counter during the scan
      if (state_ff == ST_OWN)       cnt_ff <= '0;
      else if (state_ff == ST_SCAN) cnt_ff <= cnt_ff + 1'b1;

      // latch the item, clear the result and the accumulators other than the own score
      if (req_take) begin
         op_ff         <= op_type'(req_op);
         node_id_ff    <= req_id;
         node_ip_ff    <= req_node_ip;
         node_port_ff  <= req_node_port;
         rsp_accepted  <= 1'b0;
         rsp_slot      <= '0;
         rsp_fan_out   <= 1'b0;
         rsp_dest_ip   <= '0;
         rsp_dest_port <= '0;
         best_ff       <= '0;
         pick_ff       <= '0;
         found_ff      <= 1'b0;
         stop_ff       <= 1'b0;
         better_ff     <= 1'b0;
         same_ff       <= 1'b0;
      end

      // fold each score as it leaves the prefix unit
      if (s2_tag_ff.valid) begin
         if (s2_tag_ff.own) begin
            own_score_ff <= s2_score_ff;
         end else if (op_ff == OP_RESPONDER) begin
            if (!stop_ff) begin
               priority if (s2_tag_ff.empty) begin
                  pick_ff  <= s2_idx_ff;
                  found_ff <= 1'b1;
                  stop_ff  <= 1'b1;
               end else if (s2_score_ff > best_ff && own_score_ff > s2_score_ff) begin
                  best_ff  <= s2_score_ff;
                  pick_ff  <= s2_idx_ff;
                  found_ff <= 1'b1;
               end
            end
         end else begin
            if (own_score_ff > s2_score_ff) better_ff <= 1'b1;
            if (s2_tag_ff.same)             same_ff   <= 1'b1;
         end
      end

      // form the result once the pipeline is empty
      if (state_ff == ST_DRAIN && drain_done) begin
         if (op_ff == OP_RESPONDER) begin
            if (found_ff) begin
               rsp_accepted <= 1'b1;
               rsp_slot     <= SLOT_OUT_W'(pick_ff);
            end
         end else if (better_ff && !same_ff) begin
            rsp_fan_out   <= 1'b1;
            rsp_dest_ip   <= node_ip_ff;
            rsp_dest_port <= node_port_ff;
         end
      end
   end

   // checks
   `LFU_ASSERT_NOW(a_one_kind, clock, reset, rsp_valid,
      !(rsp_accepted && rsp_fan_out), "responder and candidate result mixed")
   `LFU_ASSERT_NOW(a_slot_zero, clock, reset, rsp_valid && !rsp_accepted,
      rsp_slot == '0, "slot nonzero without store")
   `LFU_ASSERT_NOW(a_idle_empty, clock, reset, state_ff == ST_IDLE,
      !s1_tag_ff.valid && !s2_tag_ff.valid, "prefix unit busy while idle")
   `LFU_ASSERT_NEXT(a_own_first, clock, reset, state_ff == ST_OWN,
      s1_tag_ff.valid && s1_tag_ff.own, "own score pass not issued")

endmodule

/* bench/tb_lookup_frontier_update_core.sv */
// Self-checking bench for lookup_frontier_update_core: directed table, then random lookups.
// Depends on lfu_pkg and the core RTL; results are checked against the table or a frontier model.
`timescale 1ns / 1ps

module tb_lookup_frontier_update_core;
   import lfu_pkg::*;

   localparam int SLOTS         = 8;
   localparam int ID_BITS       = FULL_ID_W;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 800;
   localparam int QUIET_TAIL    = 120;
   localparam int FLUSH_CYCLES  = SLOTS + 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef logic [ID_BITS-1:0] id_type;

   typedef struct packed {
      logic                  accepted;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  fan_out;
      logic [IP_W-1:0]       dest_ip;
      logic [PORT_W-1:0]     dest_port;
   } reply_type;

   typedef struct {
      op_type            op;
      id_type            id;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      bit                typed;
      reply_type         want;
   } script_row_type;

   // DUT signals
   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   op_type                req_op;
   logic [TOP_W-1:0]      req_node_top;
   logic [MID_W-1:0]      req_node_middle;
   logic [BOT_W-1:0]      req_node_bottom;
   logic [IP_W-1:0]       req_node_ip;
   logic [PORT_W-1:0]     req_node_port;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_accepted;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic                  rsp_fan_out;
   logic [IP_W-1:0]       rsp_dest_ip;
   logic [PORT_W-1:0]     rsp_dest_port;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // frontier model state
   id_type            target_id;
   id_type            slot_id   [SLOTS];
   logic [IP_W-1:0]   slot_ip   [SLOTS];
   logic [PORT_W-1:0] slot_port [SLOTS];
   bit                lookup_on;

   reply_type      pending_replies [$];
   script_row_type script [DIRECTED_ROWS];
   int             mismatch_count = 0;
   int             items_done = 0;
   bit             quiet = 1'b0;
   int             stall_left = 0;
   int             calm_left = 0;

   lookup_frontier_update_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_node_top    (req_node_top),
      .req_node_middle (req_node_middle),
      .req_node_bottom (req_node_bottom),
      .req_node_ip     (req_node_ip),
      .req_node_port   (req_node_port),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_accepted    (rsp_accepted),
      .rsp_slot        (rsp_slot),
      .rsp_fan_out     (rsp_fan_out),
      .rsp_dest_ip     (rsp_dest_ip),
      .rsp_dest_port   (rsp_dest_port),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // give up after a generous fixed time
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // common prefix length of two IDs, counted from the most significant bit
   function automatic int prefix_len(id_type a, id_type b);
      int n;
      for (n = 0; n < ID_BITS; n++) begin
         if (a[ID_BITS-1-n] != b[ID_BITS-1-n]) return n;
      end
      return ID_BITS;
   endfunction

   // advance the frontier by one item and return the result it causes
   function automatic reply_type frontier_update(op_type op, id_type id,
                                                 logic [IP_W-1:0] ip,
                                                 logic [PORT_W-1:0] port);
      reply_type r;
      int        mine;
      int        theirs;
      int        best;
      int        pick;
      int        i;
      bit        found;
      bit        better;
      bit        same;
      r = '0;
      case (op)
         OP_START: begin
            for (i = 0; i < SLOTS; i++) slot_port[i] = '0;
            lookup_on = 1'b1;
         end
         OP_FINISH: begin
            lookup_on = 1'b0;
         end
         default: begin
            if (lookup_on) begin
               mine = prefix_len(id, target_id);
               if (op == OP_RESPONDER) begin
                  found = 1'b0;
                  best  = 0;
                  pick  = 0;
                  // first empty slot wins, else the best nonzero score beaten
                  for (i = 0; i < SLOTS; i++) begin
                     if (slot_port[i] == '0) begin
                        pick  = i;
                        found = 1'b1;
                        break;
                     end
                     theirs = prefix_len(slot_id[i], target_id);
                     if (theirs > best && mine > theirs) begin
                        best  = theirs;
                        pick  = i;
                        found = 1'b1;
                     end
                  end
                  if (found) begin
                     slot_id[pick]   = id;
                     slot_ip[pick]   = ip;
                     slot_port[pick] = port;
                     r.accepted      = 1'b1;
                     r.slot          = SLOT_OUT_W'(pick);
                  end
               end else begin
                  better = 1'b0;
                  same   = 1'b0;
                  // empty slots still take part with the ID they hold
                  for (i = 0; i < SLOTS; i++) begin
                     if (mine > prefix_len(slot_id[i], target_id)) better = 1'b1;
                     if (slot_id[i] == id) same = 1'b1;
                  end
                  if (better && !same) begin
                     r.fan_out   = 1'b1;
                     r.dest_ip   = ip;
                     r.dest_port = port;
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic id_type random_id();
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   // ID with the given prefix length against the current target
   function automatic id_type near_target(int score);
      id_type flip;
      if (score >= ID_BITS) return target_id;
      flip = id_type'(1) << (ID_BITS - 1 - score);
      return target_id ^ flip ^ (random_id() & (flip - 1'b1));
   endfunction

   // ID with prefix length k against an all-zero target
   function automatic id_type score_bit(int k);
      return id_type'(1) << (ID_BITS - 1 - k);
   endfunction

   function automatic reply_type reply_of(logic acc, int slot, logic fan,
                                          logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
      reply_type r;
      r.accepted  = acc;
      r.slot      = SLOT_OUT_W'(slot);
      r.fan_out   = fan;
      r.dest_ip   = ip;
      r.dest_port = port;
      return r;
   endfunction

   function automatic script_row_type make_row(op_type op, id_type id, logic [IP_W-1:0] ip,
                                               logic [PORT_W-1:0] port, bit typed,
                                               reply_type want);
      script_row_type row;
      row.op    = op;
      row.id    = id;
      row.ip    = ip;
      row.port  = port;
      row.typed = typed;
      row.want  = want;
      return row;
   endfunction

   // offer one item, wait for it to be taken, then queue its expected result
   task automatic send_item(op_type op, id_type id, logic [IP_W-1:0] ip,
                            logic [PORT_W-1:0] port, bit typed, reply_type want);
      reply_type predicted;
      bit        live;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_node_top    <= id[ID_BITS-1 -: TOP_W];
      req_node_middle <= id[BOT_W +: MID_W];
      req_node_bottom <= id[BOT_W-1:0];
      req_node_ip     <= ip;
      req_node_port   <= port;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      live      = lookup_on || op == OP_START || op == OP_FINISH;
      predicted = frontier_update(op, id, ip, port);
      pending_replies.push_back(typed ? want : predicted);
      if (live) items_done++;
      if (items_done >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
   endtask

   // hold off the sender until every expected result is back
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   // write the three target words, plus one write to the unused index
   task automatic load_target(int phase);
      logic [CSR_DATA_W-1:0] word [3];
      logic [CSR_IDX_W-1:0]  reg_index [3];
      int i;
      reg_index = '{CSR_TARGET_TOP, CSR_TARGET_MIDDLE, CSR_TARGET_BOTTOM};
      case (phase % 6)
         0: word = '{'0, '0, '0};
         1: word = '{'1, '1, '1};
         2: word = '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
         3: word = '{{$urandom, $urandom}, 64'h0, 64'h0};
         default: word = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
      endcase
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SPARE;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      for (i = 0; i < 3; i++) begin
         csr_index <= reg_index[i];
         csr_wdata <= word[i];
         @(posedge clock);
         case (reg_index[i])
            CSR_TARGET_TOP:    target_id[ID_BITS-1 -: TOP_W] = word[i][TOP_W-1:0];
            CSR_TARGET_MIDDLE: target_id[BOT_W +: MID_W]     = word[i];
            CSR_TARGET_BOTTOM: target_id[BOT_W-1:0]          = word[i];
            default: ;
         endcase
      end
      csr_wr_en <= 1'b0;
   endtask

   // one lookup: start, a run of mostly responders and candidates, usually a finish
   task automatic run_lookup();
      int                n;
      int                k;
      int                r;
      int                s;
      op_type            op;
      id_type            id;
      logic [PORT_W-1:0] port;
      // drop a stray item before the start, usually while no lookup runs
      if ($urandom_range(0, 3) == 0)
         send_item($urandom_range(0, 1) ? OP_RESPONDER : OP_CANDIDATE,
                   near_target($urandom_range(0, ID_BITS)), $urandom, 16'($urandom), 1'b0, '0);
      send_item(OP_START, random_id(), $urandom, 16'($urandom), 1'b0, '0);
      n = $urandom_range(4, 40);
      for (k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            send_item(op_type'($urandom_range(0, 3)), random_id(), $urandom,
                      16'($urandom), 1'b0, '0);
         end else begin
            op = r < 9 ? OP_START : (r < 58 ? OP_RESPONDER : OP_CANDIDATE);
            s  = $urandom_range(0, 99);
            if (s < 40) id = near_target($urandom_range(0, 16));
            else if (s < 70) id = near_target($urandom_range(0, ID_BITS - 1));
            else if (s < 78) id = target_id;
            else if (s < 90) id = slot_id[$urandom_range(0, SLOTS - 1)];
            else id = random_id();
            case ($urandom_range(0, 15))
               0: port = '0;
               1: port = '1;
               default: port = 16'($urandom_range(1, 65535));
            endcase
            send_item(op, id, $urandom, port, 1'b0, '0);
         end
         if ($urandom_range(0, 63) == 0) drain_replies();
      end
      if ($urandom_range(0, 4) != 0)
         send_item(OP_FINISH, random_id(), $urandom, 16'($urandom), 1'b0, '0);
   endtask

   // random stall bursts on the result side, with calm stretches
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else if (calm_left > 0) begin
         rsp_stall <= 1'b0;
         calm_left = calm_left - 1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1: begin
               stall_left = $urandom_range(0, 11);
               rsp_stall  <= 1'b1;
            end
            2: begin
               calm_left = $urandom_range(20, 80);
               rsp_stall <= 1'b0;
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // check each taken result against the oldest expectation
   always @(posedge clock) begin : check_reply
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: result item with no expectation waiting", $time);
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            compare_field("accepted", want.accepted, rsp_accepted);
            compare_field("slot", want.slot, rsp_slot);
            compare_field("fan_out", want.fan_out, rsp_fan_out);
            compare_field("dest_ip", want.dest_ip, rsp_dest_ip);
            compare_field("dest_port", want.dest_port, rsp_dest_port);
         end
      end
   end

   initial begin : stimulus
      int i;
      int phase;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_START;
      req_node_top    = '0;
      req_node_middle = '0;
      req_node_bottom = '0;
      req_node_ip     = '0;
      req_node_port   = '0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_TARGET_TOP;
      csr_wdata       = '0;
      target_id       = '0;
      lookup_on       = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         slot_id[i]   = '0;
         slot_ip[i]   = '0;
         slot_port[i] = '0;
      end

      // directed part, target all zero so the score is the leading zero count
      script[0]  = make_row(OP_RESPONDER, '1, '1, '1, 1'b1, '0);
      script[1]  = make_row(OP_CANDIDATE, '0, '1, '1, 1'b1, '0);
      script[2]  = make_row(OP_FINISH, '1, '0, '0, 1'b1, '0);
      script[3]  = make_row(OP_START, '0, '0, '0, 1'b1, '0);
      script[4]  = make_row(OP_RESPONDER, '0, '1, '1, 1'b1, reply_of(1, 0, 0, 0, 0));
      script[5]  = make_row(OP_RESPONDER, '1, '0, 16'd1, 1'b1, reply_of(1, 1, 0, 0, 0));
      // a zero port is stored but leaves the slot empty
      script[6]  = make_row(OP_RESPONDER, score_bit(3), 32'h0A00_0001, '0, 1'b1,
                            reply_of(1, 2, 0, 0, 0));
      script[7]  = make_row(OP_RESPONDER, score_bit(3), 32'h0A00_0002, 16'h8000, 1'b1,
                            reply_of(1, 2, 0, 0, 0));
      script[8]  = make_row(OP_RESPONDER, score_bit(5), 32'h0A00_0003, 16'd101, 1'b1,
                            reply_of(1, 3, 0, 0, 0));
      script[9]  = make_row(OP_RESPONDER, score_bit(10), 32'h0A00_0004, 16'd102, 1'b1,
                            reply_of(1, 4, 0, 0, 0));
      script[10] = make_row(OP_RESPONDER, score_bit(20), 32'h0A00_0005, 16'd103, 1'b1,
                            reply_of(1, 5, 0, 0, 0));
      script[11] = make_row(OP_RESPONDER, score_bit(40), 32'h0A00_0006, 16'd104, 1'b1,
                            reply_of(1, 6, 0, 0, 0));
      script[12] = make_row(OP_RESPONDER, score_bit(80), 32'h0A00_0007, 16'd105, 1'b1,
                            reply_of(1, 7, 0, 0, 0));
      // full frontier: replace the best score beaten, never a zero score
      script[13] = make_row(OP_RESPONDER, score_bit(100), 32'h0A00_0008, 16'd106, 1'b1,
                            reply_of(1, 7, 0, 0, 0));
      script[14] = make_row(OP_RESPONDER, score_bit(4), 32'h0A00_0009, 16'd107, 1'b1,
                            reply_of(1, 2, 0, 0, 0));
      script[15] = make_row(OP_RESPONDER, '1, 32'h0A00_000A, 16'd108, 1'b1, '0);
      // candidates: exact ID match blocks fan out, zero score never fans out
      script[16] = make_row(OP_CANDIDATE, '0, 32'hC0A8_0001, 16'd6881, 1'b1, '0);
      script[17] = make_row(OP_CANDIDATE, score_bit(150), 32'hA5A5_0001, 16'h1234, 1'b1,
                            reply_of(0, 0, 1, 32'hA5A5_0001, 16'h1234));
      script[18] = make_row(OP_CANDIDATE, score_bit(0) | id_type'(1), 32'h0B00_0001,
                            16'd55, 1'b1, '0);
      script[19] = make_row(OP_CANDIDATE, score_bit(150) | id_type'(1), 32'h7F00_0001, '0,
                            1'b1, reply_of(0, 0, 1, 32'h7F00_0001, 16'h0000));
      script[20] = make_row(OP_FINISH, '0, '0, '0, 1'b1, '0);
      script[21] = make_row(OP_CANDIDATE, score_bit(150), 32'h0C00_0001, 16'd77, 1'b1, '0);
      // restart empties every slot but keeps the IDs
      script[22] = make_row(OP_START, '1, '1, '1, 1'b1, '0);
      script[23] = make_row(OP_RESPONDER, score_bit(7), 32'h0D00_0001, 16'd7, 1'b1,
                            reply_of(1, 0, 0, 0, 0));
      script[24] = make_row(OP_CANDIDATE, score_bit(8), 32'h0102_0304, 16'd9, 1'b1,
                            reply_of(0, 0, 1, 32'h0102_0304, 16'd9));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         send_item(script[i].op, script[i].id, script[i].ip, script[i].port,
                   script[i].typed, script[i].want);

      // random lookups, changing the target between phases
      phase = 0;
      while (items_done < RANDOM_ITEMS) begin
         drain_replies();
         load_target(phase);
         phase++;
         repeat ($urandom_range(3, 6)) run_lookup();
      end

      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/lfu_pkg.sv
design/lookup_frontier_update_core.sv
bench/tb_lookup_frontier_update_core.sv
